FILE: src/starburst_display_scan_encoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the starburst display scan encoder
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef STARBURST_DISPLAY_SCAN_ENCODER_ASSERT_SVH
`define STARBURST_DISPLAY_SCAN_ENCODER_ASSERT_SVH

// Condition holds at every clock edge out of reset
`define STARB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define STARB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/starb_pkg.sv
// ----------------------------------------------------------------------------
// starb_pkg
// Types, segment ROM and scan constants for the starburst scan encoder.
// ----------------------------------------------------------------------------
package starb_pkg;

  localparam int unsigned NumSlices  = 5;
  localparam int unsigned RomDepth   = 43;

  localparam logic [2:0] SLICE_POINT = 3'd4;
  localparam logic [5:0] BLANK_INDEX = 6'd42;
  localparam logic [5:0] PLUS_INDEX  = 6'd36;

  // Character codes with special handling
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_BAR       = 8'h7C;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_BACKTICK  = 8'h60;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_COLON     = 8'h3A;

  // Point bits added on the punctuation tube
  localparam logic [7:0] PT_BACKTICK = 8'h80;
  localparam logic [7:0] PT_DOT      = 8'h02;
  localparam logic [7:0] PT_COLON    = 8'h82;

  // Segment ROM, first and second byte per entry
  localparam logic [7:0] SEG_HI [RomDepth] = '{
    8'h14, 8'h00, 8'h70, 8'h70, 8'h60, 8'h70, 8'h70, 8'h08, 8'h70, 8'h70,
    8'h60, 8'h5a, 8'h10, 8'h1a, 8'h70, 8'h60, 8'h50, 8'h60, 8'h1a, 8'h10,
    8'h20, 8'h10, 8'h80, 8'h80, 8'h10, 8'h60, 8'h10, 8'h60, 8'hd0, 8'h0a,
    8'h10, 8'h04, 8'h04, 8'h84, 8'h88, 8'h14,
    8'h6a, 8'h60, 8'h8e, 8'h04, 8'h0a, 8'h80, 8'h00
  };
  localparam logic [7:0] SEG_LO [RomDepth] = '{
    8'hff, 8'h18, 8'h2c, 8'h26, 8'h32, 8'h16, 8'h1e, 8'h04, 8'hff, 8'hf7,
    8'hff, 8'h26, 8'h1c, 8'h26, 8'h1c, 8'h1c, 8'h1e, 8'hfb, 8'h04, 8'h26,
    8'h18, 8'h18, 8'hfb, 8'hfb, 8'hff, 8'hfd, 8'hff, 8'hfd, 8'h06, 8'h04,
    8'hfb, 8'h18, 8'hfb, 8'h00, 8'h00, 8'h04,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Extra-segment groups: bit 0 diagonal group A, bit 1 diagonal group B
  localparam logic [1:0] EXTRA_CLASS [RomDepth] = '{
    2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd3, 2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd2, 2'd2, 2'd0, 2'd0,
    2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd1,
    2'd0, 2'd0, 2'd3, 2'd1, 2'd0, 2'd2, 2'd0
  };

  // Per-slice contribution of each group to the accumulators
  localparam logic [7:0] GRP_A_HI [4] = '{8'h00, 8'h00, 8'h00, 8'h10};
  localparam logic [7:0] GRP_A_LO [4] = '{8'h04, 8'h20, 8'h02, 8'h00};
  localparam logic [7:0] GRP_B_HI [4] = '{8'h00, 8'h00, 8'h20, 8'h40};
  localparam logic [7:0] GRP_B_LO [4] = '{8'h08, 8'h10, 8'h00, 8'h00};

  localparam logic [7:0] SELECT_CODE [NumSlices] = '{8'hDF, 8'hFD, 8'hFB, 8'hF7, 8'hEF};

  // One scan result plus the accumulator values left behind
  typedef struct packed {
    logic [7:0] tube_select;
    logic [7:0] seg_upper;
    logic [7:0] seg_lower;
    logic [2:0] slice_index;
    logic [7:0] acc_upper;
    logic [7:0] acc_lower;
  } slice_res_t;

  // ASCII byte to ROM entry; unknown bytes fall on the entry of '0'
  function automatic logic [5:0] char_index(input logic [7:0] c);
    logic [7:0] idx;
    idx = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      idx = c - 8'd48;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      idx = c - 8'd55;
    end else if (c == CH_SPACE || c == CH_NUL) begin
      idx = {2'b00, BLANK_INDEX};
    end else if (c == CH_PLUS) begin
      idx = {2'b00, PLUS_INDEX};
    end else if (c == CH_MINUS) begin
      idx = {2'b00, PLUS_INDEX} + 8'd1;
    end else if (c == CH_STAR) begin
      idx = {2'b00, PLUS_INDEX} + 8'd2;
    end else if (c == CH_SLASH) begin
      idx = {2'b00, PLUS_INDEX} + 8'd3;
    end else if (c == CH_BAR) begin
      idx = {2'b00, PLUS_INDEX} + 8'd4;
    end else if (c == CH_BACKSLASH) begin
      idx = {2'b00, PLUS_INDEX} + 8'd5;
    end
    return idx[5:0];
  endfunction

endpackage

FILE: src/starb_slice_enc.sv
// ----------------------------------------------------------------------------
// starb_slice_enc
// Combinational encode of one scan slice: tube select, segment bytes and
// the updated extra-segment accumulators.
// ----------------------------------------------------------------------------
module starb_slice_enc (
  input  logic [2:0]            slice_i,
  input  logic [7:0]            acc_upper_i,
  input  logic [7:0]            acc_lower_i,
  input  logic [7:0]            char_first_i,
  input  logic [7:0]            char_second_i,
  input  logic [7:0]            char_third_i,
  input  logic [7:0]            char_fourth_i,
  input  logic [7:0]            point_char_i,
  output starb_pkg::slice_res_t res_o
);
  import starb_pkg::*;

  logic       is_point;
  logic [1:0] tube;
  logic [7:0] ch;
  logic [5:0] idx;
  logic [1:0] cls;
  logic [7:0] add_hi;
  logic [7:0] add_lo;
  logic [7:0] pt_bits;

  // character of the current tube
  always_comb begin
    tube = slice_i[1:0];
    case (tube)
      2'd0:    ch = char_first_i;
      2'd1:    ch = char_second_i;
      2'd2:    ch = char_third_i;
      default: ch = char_fourth_i;
    endcase
  end

  // ROM lookup and extra-segment contribution
  always_comb begin
    is_point = (slice_i >= SLICE_POINT);
    idx      = char_index(ch);
    cls      = EXTRA_CLASS[idx];
    add_hi   = (cls[0] ? GRP_A_HI[tube] : 8'h00) + (cls[1] ? GRP_B_HI[tube] : 8'h00);
    add_lo   = (cls[0] ? GRP_A_LO[tube] : 8'h00) + (cls[1] ? GRP_B_LO[tube] : 8'h00);
  end

  // point marks on the punctuation tube
  always_comb begin
    case (point_char_i)
      CH_BACKTICK: pt_bits = PT_BACKTICK;
      CH_DOT:      pt_bits = PT_DOT;
      CH_COLON:    pt_bits = PT_COLON;
      default:     pt_bits = 8'h00;
    endcase
  end

  // result word
  always_comb begin
    if (is_point) begin
      res_o.tube_select = SELECT_CODE[SLICE_POINT];
      res_o.seg_upper   = acc_upper_i + pt_bits;
      res_o.seg_lower   = acc_lower_i;
      res_o.slice_index = SLICE_POINT;
      res_o.acc_upper   = 8'h00;
      res_o.acc_lower   = 8'h00;
    end else begin
      res_o.tube_select = SELECT_CODE[{1'b0, tube}];
      res_o.seg_upper   = SEG_HI[idx];
      res_o.seg_lower   = SEG_LO[idx];
      res_o.slice_index = {1'b0, tube};
      res_o.acc_upper   = acc_upper_i + add_hi;
      res_o.acc_lower   = acc_lower_i + add_lo;
    end
  end

endmodule

FILE: src/starburst_display_scan_encoder.sv
// ----------------------------------------------------------------------------
// starburst_display_scan_encoder
// Scan encoder for a four-character starburst display with punctuation tube.
// ----------------------------------------------------------------------------
// An accepted input word goes to the result register, or to the skid register
// while the output stalls. Throughput: one word per cycle while in_stall_o is
// low; the ROM lookup and accumulator add sit between the input ports and the
// result register.
// Reset (rst_ni low, asynchronous): slice counter and accumulators clear,
// no result valid.
module starburst_display_scan_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_first_i,
  input  logic [7:0] char_second_i,
  input  logic [7:0] char_third_i,
  input  logic [7:0] char_fourth_i,
  input  logic [7:0] point_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] tube_select_o,
  output logic [7:0] segments_upper_o,
  output logic [7:0] segments_lower_o,
  output logic [2:0] slice_index_o
);
  import starb_pkg::*;

  logic [2:0] slice_q, slice_d;
  logic [7:0] acc_upper_q;
  logic [7:0] acc_lower_q;
  slice_res_t res;
  logic       in_acc;
  slice_res_t out_q;
  slice_res_t skid_q;
  logic       out_vld_q;
  logic       skid_vld_q;

  assign in_stall_o = skid_vld_q;
  assign in_acc     = in_valid_i && !skid_vld_q;

  // slice encode
  starb_slice_enc u_enc (
    .slice_i      (slice_q),
    .acc_upper_i  (acc_upper_q),
    .acc_lower_i  (acc_lower_q),
    .char_first_i (char_first_i),
    .char_second_i(char_second_i),
    .char_third_i (char_third_i),
    .char_fourth_i(char_fourth_i),
    .point_char_i (point_char_i),
    .res_o        (res)
  );

  // next slice: wrap after the punctuation tube
  assign slice_d = (slice_q >= SLICE_POINT) ? 3'd0 : slice_q + 3'd1;

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q     <= 3'd0;
      acc_upper_q <= 8'h00;
      acc_lower_q <= 8'h00;
    end else if (in_acc) begin
      slice_q     <= slice_d;
      acc_upper_q <= res.acc_upper;
      acc_lower_q <= res.acc_lower;
    end
  end

  // output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || !out_stall_i) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q  <= in_acc;
      end
    end else if (in_acc) begin
      skid_vld_q <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (!out_vld_q || !out_stall_i) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res;
      end
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign tube_select_o    = out_q.tube_select;
  assign segments_upper_o = out_q.seg_upper;
  assign segments_lower_o = out_q.seg_lower;
  assign slice_index_o    = out_q.slice_index;

  `include "starburst_display_scan_encoder_assert.svh"

  `STARB_ASSERT_ALWAYS(a_skid_implies_out, !skid_vld_q || out_vld_q, "skid full, output empty")
  `STARB_ASSERT_ALWAYS(a_slice_range, slice_q <= SLICE_POINT, "slice counter out of range")
  `STARB_ASSERT_NEXT(a_point_clears, in_acc && slice_q == SLICE_POINT, slice_q == 3'd0 && acc_upper_q == 8'h00 && acc_lower_q == 8'h00, "accumulators not cleared after point slice")
  `STARB_ASSERT_NEXT(a_slice_step, in_acc && slice_q < SLICE_POINT, slice_q == $past(slice_q) + 3'd1, "slice counter did not advance")
  `STARB_ASSERT_NEXT(a_accept_valid, in_acc, out_vld_q, "accepted word produced no result")

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for starburst_display_scan_encoder
// Drives scan words through the valid/stall input channel and checks every
// result word, field by field, against its typed-in directed result or a
// cycle-free scan predictor with its own slice counter and diagonal accumulators.
// A short directed table comes first. Then come random words over three idling
// phases, with one long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
  import starb_pkg::*;

  localparam int RandomWords = 650;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 48;
  localparam int DirRows     = 25;

  typedef struct packed {
    logic [7:0] tube;
    logic [7:0] upper;
    logic [7:0] lower;
    logic [2:0] slice;
  } scan_word_t;

  // One directed row: the five input bytes and, where obvious, the result
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
    logic [7:0] fourth;
    logic [7:0] point;
    logic       typed;
    scan_word_t word;
  } scan_row_t;

  // Glyph tables of the predictor
  localparam logic [7:0] GlyphHi [43] = '{
    8'h14, 8'h00, 8'h70, 8'h70, 8'h60, 8'h70, 8'h70, 8'h08, 8'h70, 8'h70,
    8'h60, 8'h5a, 8'h10, 8'h1a, 8'h70, 8'h60, 8'h50, 8'h60, 8'h1a, 8'h10,
    8'h20, 8'h10, 8'h80, 8'h80, 8'h10, 8'h60, 8'h10, 8'h60, 8'hd0, 8'h0a,
    8'h10, 8'h04, 8'h04, 8'h84, 8'h88, 8'h14,
    8'h6a, 8'h60, 8'h8e, 8'h04, 8'h0a, 8'h80, 8'h00
  };
  localparam logic [7:0] GlyphLo [43] = '{
    8'hff, 8'h18, 8'h2c, 8'h26, 8'h32, 8'h16, 8'h1e, 8'h04, 8'hff, 8'hf7,
    8'hff, 8'h26, 8'h1c, 8'h26, 8'h1c, 8'h1c, 8'h1e, 8'hfb, 8'h04, 8'h26,
    8'h18, 8'h18, 8'hfb, 8'hfb, 8'hff, 8'hfd, 8'hff, 8'hfd, 8'h06, 8'h04,
    8'hfb, 8'h18, 8'hfb, 8'h00, 8'h00, 8'h04,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };
  // bit 0: diagonal group A, bit 1: diagonal group B
  localparam logic [1:0] GlyphDiag [43] = '{
    2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd3, 2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd2, 2'd2, 2'd0, 2'd0,
    2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd1,
    2'd0, 2'd0, 2'd3, 2'd1, 2'd0, 2'd2, 2'd0
  };
  localparam logic [7:0] DiagAHi [4] = '{8'h00, 8'h00, 8'h00, 8'h10};
  localparam logic [7:0] DiagALo [4] = '{8'h04, 8'h20, 8'h02, 8'h00};
  localparam logic [7:0] DiagBHi [4] = '{8'h00, 8'h00, 8'h20, 8'h40};
  localparam logic [7:0] DiagBLo [4] = '{8'h08, 8'h10, 8'h00, 8'h00};
  localparam logic [7:0] TubeSel [5] = '{8'hDF, 8'hFD, 8'hFB, 8'hF7, 8'hEF};

  // Directed scan frames: blanks, unknown bytes, every point mark, full diagonals
  localparam scan_row_t DirectedRows [DirRows] = '{
    // all blank after reset, no point mark
    '{8'h20, 8'h20, 8'h20, 8'h20, 8'h00, 1'b1, '{8'hDF, 8'h00, 8'h00, 3'd0}},
    '{8'h20, 8'h20, 8'h20, 8'h20, 8'h00, 1'b1, '{8'hFD, 8'h00, 8'h00, 3'd1}},
    '{8'h20, 8'h20, 8'h20, 8'h20, 8'h00, 1'b1, '{8'hFB, 8'h00, 8'h00, 3'd2}},
    '{8'h20, 8'h20, 8'h20, 8'h20, 8'h00, 1'b1, '{8'hF7, 8'h00, 8'h00, 3'd3}},
    '{8'h20, 8'h20, 8'h20, 8'h20, 8'h00, 1'b1, '{8'hEF, 8'h00, 8'h00, 3'd4}},
    // all 0xFF: unknown, shown as '0'; backtick mark
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h60, 1'b1, '{8'hDF, 8'h14, 8'hFF, 3'd0}},
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h60, 1'b1, '{8'hFD, 8'h14, 8'hFF, 3'd1}},
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h60, 1'b1, '{8'hFB, 8'h14, 8'hFF, 3'd2}},
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h60, 1'b1, '{8'hF7, 8'h14, 8'hFF, 3'd3}},
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h60, 1'b0, '0},
    // NUL blank, lower case, high byte, 'Z'; dot mark
    '{8'h00, 8'h7A, 8'h41, 8'h39, 8'h2E, 1'b1, '{8'hDF, 8'h00, 8'h00, 3'd0}},
    '{8'h30, 8'h61, 8'h41, 8'h39, 8'h2E, 1'b1, '{8'hFD, 8'h14, 8'hFF, 3'd1}},
    '{8'h30, 8'h41, 8'h80, 8'h39, 8'h2E, 1'b1, '{8'hFB, 8'h14, 8'hFF, 3'd2}},
    '{8'h30, 8'h41, 8'h39, 8'h5A, 8'h2E, 1'b0, '0},
    '{8'h30, 8'h41, 8'h39, 8'h5A, 8'h2E, 1'b0, '0},
    // both diagonal groups on the first, third and fourth tubes; colon mark
    '{8'h2A, 8'h5C, 8'h4B, 8'h2A, 8'h3A, 1'b0, '0},
    '{8'h2A, 8'h5C, 8'h4B, 8'h2A, 8'h3A, 1'b0, '0},
    '{8'h2A, 8'h5C, 8'h4B, 8'h2A, 8'h3A, 1'b0, '0},
    '{8'h2A, 8'h5C, 8'h4B, 8'h2A, 8'h3A, 1'b0, '0},
    '{8'h2A, 8'h5C, 8'h4B, 8'h2A, 8'h3A, 1'b0, '0},
    // remaining symbols; 0xFF on the point tube adds nothing
    '{8'h2B, 8'h2D, 8'h2F, 8'h7C, 8'hFF, 1'b0, '0},
    '{8'h2B, 8'h2D, 8'h2F, 8'h7C, 8'hFF, 1'b0, '0},
    '{8'h2B, 8'h2D, 8'h2F, 8'h7C, 8'hFF, 1'b0, '0},
    '{8'h2B, 8'h2D, 8'h2F, 8'h7C, 8'hFF, 1'b0, '0},
    '{8'h2B, 8'h2D, 8'h2F, 8'h7C, 8'hFF, 1'b0, '0}
  };

  logic       clk_i;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall_o;
  logic [7:0] char_first;
  logic [7:0] char_second;
  logic [7:0] char_third;
  logic [7:0] char_fourth;
  logic [7:0] point_char;
  logic       out_valid_o;
  logic       out_stall;
  logic [7:0] tube_select_o;
  logic [7:0] segments_upper_o;
  logic [7:0] segments_lower_o;
  logic [2:0] slice_index_o;

  // Typed-in result travelling alongside the word on the input channel
  logic       in_typed;
  scan_word_t in_typed_word;

  // Predictor state
  logic [2:0] scan_slice;
  logic [7:0] diag_acc_upper;
  logic [7:0] diag_acc_lower;
  scan_word_t expected_words [$];

  int errors;
  int cycles;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  bit hold_request;

  starburst_display_scan_encoder u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .char_first_i     (char_first),
    .char_second_i    (char_second),
    .char_third_i     (char_third),
    .char_fourth_i    (char_fourth),
    .point_char_i     (point_char),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .tube_select_o    (tube_select_o),
    .segments_upper_o (segments_upper_o),
    .segments_lower_o (segments_lower_o),
    .slice_index_o    (slice_index_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ASCII byte to glyph entry; anything unknown shows as '0'
  function automatic logic [5:0] glyph_entry(input logic [7:0] c);
    logic [7:0] offs;
    offs = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      offs = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      offs = c - 8'h37;
    end else begin
      case (c)
        CH_SPACE, CH_NUL: offs = {2'b00, BLANK_INDEX};
        CH_PLUS:          offs = {2'b00, PLUS_INDEX};
        CH_MINUS:         offs = {2'b00, PLUS_INDEX} + 8'd1;
        CH_STAR:          offs = {2'b00, PLUS_INDEX} + 8'd2;
        CH_SLASH:         offs = {2'b00, PLUS_INDEX} + 8'd3;
        CH_BAR:           offs = {2'b00, PLUS_INDEX} + 8'd4;
        CH_BACKSLASH:     offs = {2'b00, PLUS_INDEX} + 8'd5;
        default:          offs = 8'd0;
      endcase
    end
    return offs[5:0];
  endfunction

  // One scan tick: result word for the current slice, advances the state
  function automatic scan_word_t scan_tick(input logic [7:0] first, second, third,
                                           fourth, point);
    logic [7:0] tube_char;
    logic [5:0] entry;
    logic [1:0] diag;
    logic [7:0] marks;
    scan_word_t w;
    if (scan_slice < SLICE_POINT) begin
      case (scan_slice)
        3'd0:    tube_char = first;
        3'd1:    tube_char = second;
        3'd2:    tube_char = third;
        default: tube_char = fourth;
      endcase
      entry = glyph_entry(tube_char);
      diag  = GlyphDiag[entry];
      if (diag[0]) begin
        diag_acc_upper = diag_acc_upper + DiagAHi[scan_slice[1:0]];
        diag_acc_lower = diag_acc_lower + DiagALo[scan_slice[1:0]];
      end
      if (diag[1]) begin
        diag_acc_upper = diag_acc_upper + DiagBHi[scan_slice[1:0]];
        diag_acc_lower = diag_acc_lower + DiagBLo[scan_slice[1:0]];
      end
      w = '{TubeSel[scan_slice], GlyphHi[entry], GlyphLo[entry], scan_slice};
      scan_slice = scan_slice + 3'd1;
    end else begin
      case (point)
        CH_BACKTICK: marks = PT_BACKTICK;
        CH_DOT:      marks = PT_DOT;
        CH_COLON:    marks = PT_COLON;
        default:     marks = 8'h00;
      endcase
      w = '{TubeSel[4], diag_acc_upper + marks, diag_acc_lower, SLICE_POINT};
      diag_acc_upper = 8'h00;
      diag_acc_lower = 8'h00;
      scan_slice     = 3'd0;
    end
    return w;
  endfunction

  // Mostly displayable characters, the rest any byte
  function automatic logic [7:0] pick_char();
    int r;
    int k;
    r = $urandom_range(9);
    k = $urandom_range(35);
    if (r < 3) return 8'($urandom_range(255));
    if (r < 8) return (k < 10) ? 8'(8'h30 + k) : 8'(8'h41 + k - 10);
    case ($urandom_range(7))
      0:       return CH_SPACE;
      1:       return CH_NUL;
      2:       return CH_PLUS;
      3:       return CH_MINUS;
      4:       return CH_STAR;
      5:       return CH_SLASH;
      6:       return CH_BAR;
      default: return CH_BACKSLASH;
    endcase
  endfunction

  function automatic logic [7:0] pick_point();
    case ($urandom_range(4))
      0:       return CH_BACKTICK;
      1:       return CH_DOT;
      2:       return CH_COLON;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want, got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Offer one word from a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic [7:0] c0, c1, c2, c3, pt,
                           input logic typed, input scan_word_t tw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid      <= 1'b1;
    char_first    <= c0;
    char_second   <= c1;
    char_third    <= c2;
    char_fourth   <= c3;
    point_char    <= pt;
    in_typed      <= typed;
    in_typed_word <= tw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Predict accepted input words, check accepted result words
  always @(posedge clk_i) begin
    scan_word_t got;
    scan_word_t want;
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        got = '{tube_select_o, segments_upper_o, segments_lower_o, slice_index_o};
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %h", $time, got);
          errors++;
        end else begin
          want = expected_words.pop_front();
          compare_field("tube_select", want.tube, got.tube);
          compare_field("segments_upper", want.upper, got.upper);
          compare_field("segments_lower", want.lower, got.lower);
          compare_field("slice_index", {5'd0, want.slice}, {5'd0, got.slice});
        end
      end
      if (in_valid && !in_stall_o) begin
        want = scan_tick(char_first, char_second, char_third, char_fourth, point_char);
        expected_words.push_back(in_typed ? in_typed_word : want);
      end
    end
  end

  // Receiver: random stall, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Main sequence
  initial begin
    errors         = 0;
    cycles         = 0;
    hold_request   = 1'b0;
    send_idle_pct  = 29;
    recv_idle_pct  = 58;
    scan_slice     = 3'd0;
    diag_acc_upper = 8'h00;
    diag_acc_lower = 8'h00;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    char_first     = 8'h00;
    char_second    = 8'h00;
    char_third     = 8'h00;
    char_fourth    = 8'h00;
    point_char     = 8'h00;
    in_typed       = 1'b0;
    in_typed_word  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // directed table
    for (int i = 0; i < DirRows; i++) begin
      send_word(DirectedRows[i].first, DirectedRows[i].second, DirectedRows[i].third,
                DirectedRows[i].fourth, DirectedRows[i].point, DirectedRows[i].typed,
                DirectedRows[i].word);
    end

    // random words over three idling phases
    for (int i = 0; i < RandomWords; i++) begin
      if (i == RandomWords / 3) begin
        send_idle_pct = 58;
        recv_idle_pct = 29;
      end
      if (i == 2 * RandomWords / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
      end
      send_word(pick_char(), pick_char(), pick_char(), pick_char(), pick_point(),
                1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
